// ===== hw/rtl/hlfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlfs_pkg
// Shared types and constants for the hex length frame scanner.
// ----------------------------------------------------------------------------
package hlfs_pkg;

  // header is four hex characters, and its length counts those characters
  localparam int unsigned HDR_CHARS = 4;
  localparam logic [15:0] HDR_LEN   = 16'd4;
  // digits gathered before the last header character arrives
  localparam int unsigned ACC_BITS  = 12;
  localparam int unsigned OUT_COUNT_BITS = 16;

  // decoded hex character
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

  // one buffer result
  typedef struct packed {
    logic                      status;
    logic [OUT_COUNT_BITS-1:0] packet_count;
  } result_t;

  // ascii hex character to nibble, non-hex reads as zero and not ok
  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    n.ok  = 1'b1;
    n.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n.val = 4'(c - 8'h37);
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hex_length_frame_scanner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_length_frame_scanner_top
// Framing checker for buffers of packets with 4-character hex length headers.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock while in_stall is low, with no gaps
// between buffers. Each byte updates the registered framing state; the byte
// marked last produces one result (status, packet count), registered into
// the output entry of a two-entry buffer, or into its skid entry while the
// output side holds an earlier result. Input stalls only when both entries
// hold results not yet taken. Bytes after a framing error are skipped until
// the last byte; the count saturates at 2^COUNT_BITS-1 or 65535, whichever
// is smaller, and reads zero when status flags an error.
// ----------------------------------------------------------------------------
module hex_length_frame_scanner_top #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [15:0]      out_packet_count
);
  import hlfs_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    q_full;

  assign in_stall  = q_full;
  assign in_accept = in_valid & ~q_full;

  // framing state
  hlfs_scan_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .last      (in_last),
    .res_valid (res_valid),
    .res       (res)
  );

  // result buffer
  hlfs_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status       = out_data.status;
  assign out_packet_count = out_data.packet_count;

endmodule
`default_nettype wire

// ===== hw/rtl/hlfs_scan_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlfs_scan_core
// Per-byte framing state update; emits one result on the last byte.
// ----------------------------------------------------------------------------
module hlfs_scan_core #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last,
  output logic                  res_valid,
  output hlfs_pkg::result_t     res
);
  import hlfs_pkg::*;

  // counter width, capped at the result field width
  localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam logic [CW-1:0] CAP = {CW{1'b1}};

  logic                in_body_r,  in_body_nxt;
  logic [1:0]          pos_r,      pos_nxt;
  logic [ACC_BITS-1:0] acc_r,      acc_nxt;
  logic                pend_r,     pend_nxt;
  logic [15:0]         body_r,     body_nxt;
  logic [CW-1:0]       cnt_r,      cnt_nxt;
  logic                err_r,      err_nxt;

  nibble_t     nib;
  logic        bad_digit;
  logic [15:0] plen;
  logic [15:0] body_dec;
  logic        err_fin;
  logic        count_inc;

  assign nib       = hex_nibble(data_byte);
  assign bad_digit = pend_r | ~nib.ok;
  assign plen      = {acc_r, nib.val};
  assign body_dec  = body_r - 16'd1;

  // next state for one accepted byte
  always_comb begin
    in_body_nxt = in_body_r;
    pos_nxt     = pos_r;
    acc_nxt     = acc_r;
    pend_nxt    = pend_r;
    body_nxt    = body_r;
    err_nxt     = err_r;
    count_inc   = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    err_fin     = 1'b0;
    cnt_nxt     = cnt_r;

    if (accept) begin
      if (!err_r) begin
        if (in_body_r) begin
          // skip body byte
          body_nxt = body_dec;
          if (body_dec == 16'd0) begin
            in_body_nxt = 1'b0;
            count_inc   = 1'b1;
          end
        end else if (pos_r == 2'(HDR_CHARS - 1)) begin
          // header complete
          pos_nxt  = 2'd0;
          acc_nxt  = '0;
          pend_nxt = 1'b0;
          if (bad_digit || plen < HDR_LEN) begin
            err_nxt = 1'b1;
          end else if (plen == HDR_LEN) begin
            count_inc = 1'b1;
          end else begin
            body_nxt    = plen - HDR_LEN;
            in_body_nxt = 1'b1;
          end
        end else begin
          // gather header digit
          pos_nxt  = pos_r + 2'd1;
          acc_nxt  = plen[ACC_BITS-1:0];
          pend_nxt = bad_digit;
        end
      end

      // saturating packet count
      if (count_inc && cnt_r != CAP) begin
        cnt_nxt = cnt_r + CW'(1);
      end

      // end of buffer: report and return to reset state
      if (last) begin
        err_fin          = err_nxt | (in_body_nxt && body_nxt != 16'd0);
        res_valid        = 1'b1;
        res.status       = err_fin;
        res.packet_count = err_fin ? '0 : OUT_COUNT_BITS'(cnt_nxt);
        in_body_nxt      = 1'b0;
        pos_nxt          = 2'd0;
        acc_nxt          = '0;
        pend_nxt         = 1'b0;
        body_nxt         = '0;
        cnt_nxt          = '0;
        err_nxt          = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      pos_r     <= 2'd0;
      acc_r     <= '0;
      pend_r    <= 1'b0;
      body_r    <= '0;
      cnt_r     <= '0;
      err_r     <= 1'b0;
    end else begin
      in_body_r <= in_body_nxt;
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      pend_r    <= pend_nxt;
      body_r    <= body_nxt;
      cnt_r     <= cnt_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hlfs_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlfs_out_queue
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module hlfs_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hlfs_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hlfs_pkg::result_t      out_data
);
  import hlfs_pkg::*;

  logic    head_valid_r, head_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t head_r,       head_nxt;
  result_t skid_r,       skid_nxt;
  logic    pop;

  assign pop       = head_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  // buffer control; a push only comes while the skid entry is free
  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!head_valid_r || pop) begin
      head_valid_nxt = push;
      head_nxt       = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire
